[rtl/core/cdq_pkg.sv]
// cdq_pkg: shared types and constants of the circular deque
// operation and status codes, ring geometry, controller state and command word
// no dependencies
package cdq_pkg;

    localparam int DEPTH  = 8;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORD_W = 32;

    localparam logic [1:0] OP_PUSH_BACK  = 2'd0;
    localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_BACK   = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL_DROP = 2'd1;
    localparam logic [1:0] ST_EMPTY_POP = 2'd2;

    localparam logic signed [WORD_W-1:0] VALUE_EMPTY = -32'sd1;
    localparam logic signed [WORD_W-1:0] VALUE_PUSH  = 32'sd0;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic {
        CTL_IDLE,
        CTL_LOAD
    } ctl_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take;  // word accepted this cycle
        logic load;  // move pending result into the output register
    } cdq_cmd_t;

    function automatic idx_t next_slot(input idx_t i);
        next_slot = (i == IDX_LAST) ? '0 : i + idx_t'(1);
    endfunction

    function automatic idx_t prev_slot(input idx_t i);
        prev_slot = (i == '0) ? IDX_LAST : i - idx_t'(1);
    endfunction

endpackage

[rtl/core/cdq_if.sv]
// cdq_req_if and cdq_rsp_if: valid/ready channels of the circular deque
// depends on cdq_pkg for word width
interface cdq_req_if;
    logic                                       valid;
    logic                                       ready;
    logic [1:0]                                 op;
    logic signed [cdq_pkg::WORD_W-1:0]          data_in;

    modport source (output valid, output op, output data_in, input ready);
    modport sink (input valid, input op, input data_in, output ready);
endinterface

interface cdq_rsp_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [cdq_pkg::WORD_W-1:0]          value_out;
    logic [1:0]                                 status;
    logic                                       now_empty;
    logic                                       now_full;

    modport source (output valid, output value_out, output status, output now_empty,
                    output now_full, input ready);
    modport sink (input valid, input value_out, input status, input now_empty,
                  input now_full, output ready);
endinterface

[rtl/core/cdq_ctl.sv]
// cdq_ctl: handshake controller of the circular deque
// sequences accept, ring access and output load; depends on cdq_pkg
module cdq_ctl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output cdq_pkg::cdq_cmd_t cmd
);
    import cdq_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTL_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        case (state_reg)
            CTL_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = CTL_LOAD;
                end
            end
            CTL_LOAD:
            begin
                // output register free or being emptied this cycle
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
        rsp_valid_next = cmd.load | (rsp_valid_reg & ~rsp_ready);
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

[rtl/core/cdq_dp.sv]
// cdq_dp: datapath of the circular deque
// ring memory, head/tail indices, pending result and output register; depends on cdq_pkg
module cdq_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cdq_pkg::cdq_cmd_t                 cmd,
    input  logic [1:0]                        op,
    input  logic signed [cdq_pkg::WORD_W-1:0] data_in,
    output logic signed [cdq_pkg::WORD_W-1:0] value_out,
    output logic [1:0]                        status,
    output logic                              now_empty,
    output logic                              now_full
);
    import cdq_pkg::*;

    logic signed [WORD_W-1:0] ring_mem [DEPTH];

    idx_t head_reg, head_next;
    idx_t tail_reg, tail_next;
    logic holds_reg, holds_next;

    logic signed [WORD_W-1:0] rd_data_reg;
    logic signed [WORD_W-1:0] pend_value_reg, pend_value_next;
    logic [1:0]               pend_status_reg, pend_status_next;
    logic                     pend_rd_reg, pend_rd_next;
    logic                     pend_empty_reg, pend_empty_next;
    logic                     pend_full_reg, pend_full_next;

    logic signed [WORD_W-1:0] value_out_reg;
    logic [1:0]               status_reg;
    logic                     now_empty_reg;
    logic                     now_full_reg;

    logic is_full;
    logic wr_en;
    idx_t wr_addr;
    logic rd_en;
    idx_t rd_addr;

    always_comb
    begin
        is_full          = holds_reg && (next_slot(tail_reg) == head_reg);
        head_next        = head_reg;
        tail_next        = tail_reg;
        holds_next       = holds_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        rd_en            = 1'b0;
        rd_addr          = head_reg;
        pend_value_next  = VALUE_PUSH;
        pend_status_next = ST_DONE;
        pend_rd_next     = 1'b0;
        if (!op[1])
        begin
            if (is_full)
            begin
                pend_status_next = ST_FULL_DROP;
            end
            else if (!holds_reg)
            begin
                // first word always lands in slot zero
                head_next  = '0;
                tail_next  = '0;
                holds_next = 1'b1;
                wr_en      = 1'b1;
                wr_addr    = '0;
            end
            else if (op == OP_PUSH_BACK)
            begin
                tail_next = next_slot(tail_reg);
                wr_en     = 1'b1;
                wr_addr   = tail_next;
            end
            else
            begin
                head_next = prev_slot(head_reg);
                wr_en     = 1'b1;
                wr_addr   = head_next;
            end
        end
        else
        begin
            if (!holds_reg)
            begin
                pend_status_next = ST_EMPTY_POP;
                pend_value_next  = VALUE_EMPTY;
            end
            else
            begin
                rd_en        = 1'b1;
                rd_addr      = (op == OP_POP_FRONT) ? head_reg : tail_reg;
                pend_rd_next = 1'b1;
                if (head_reg == tail_reg)
                begin
                    holds_next = 1'b0;
                    head_next  = '0;
                    tail_next  = '0;
                end
                else if (op == OP_POP_FRONT)
                begin
                    head_next = next_slot(head_reg);
                end
                else
                begin
                    tail_next = prev_slot(tail_reg);
                end
            end
        end
        pend_empty_next = !holds_next;
        pend_full_next  = holds_next && (next_slot(tail_next) == head_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            holds_reg <= 1'b0;
        end
        else if (cmd.take)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            holds_reg <= holds_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && wr_en)
        begin
            ring_mem[wr_addr] <= data_in;
        end
        if (cmd.take && rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            pend_value_reg  <= pend_value_next;
            pend_status_reg <= pend_status_next;
            pend_rd_reg     <= pend_rd_next;
            pend_empty_reg  <= pend_empty_next;
            pend_full_reg   <= pend_full_next;
        end
        if (cmd.load)
        begin
            value_out_reg <= pend_rd_reg ? rd_data_reg : pend_value_reg;
            status_reg    <= pend_status_reg;
            now_empty_reg <= pend_empty_reg;
            now_full_reg  <= pend_full_reg;
        end
    end

    assign value_out = value_out_reg;
    assign status    = status_reg;
    assign now_empty = now_empty_reg;
    assign now_full  = now_full_reg;

endmodule

[rtl/core/circular_deque.sv]
// circular_deque: double-ended queue of signed 32-bit words in a ring memory
// top level; depends on cdq_pkg, cdq_if, cdq_ctl and cdq_dp
//
// usage:
//   req carries one operation per word: op (push back, push front, pop front,
//   pop back) and data_in, the value to push. rsp returns one word per
//   operation: value_out (popped value, -1 on a pop from empty, 0 for pushes),
//   status (done, push dropped on full, pop on empty) and the empty and full
//   flags after the operation.
//   a word is taken when valid and ready are both high at a rising edge.
//   a taken request has its result held in the pending registers (and, for a
//   pop, in the ring read register); the output register loads it from there.
//   the ring memory has a registered read port, so each operation makes its
//   ring access and then moves its result into the output register; a new
//   request is taken only once the previous result has been loaded.
//   while a result waits on rsp, one more request is still taken and its
//   result held in a pending register; req.ready then stays low until the
//   output register frees up.
//   reset (rst_n low) empties the deque; the ring contents are not cleared
//   and need no clearing pass, since only pushed slots are ever read.
module circular_deque (
    input  logic      clk,
    input  logic      rst_n,
    cdq_req_if.sink   req,
    cdq_rsp_if.source rsp
);
    import cdq_pkg::*;

    cdq_cmd_t cmd;

    cdq_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    cdq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .op        (req.op),
        .data_in   (req.data_in),
        .value_out (rsp.value_out),
        .status    (rsp.status),
        .now_empty (rsp.now_empty),
        .now_full  (rsp.now_full)
    );

`ifndef ASSERT_OFF
    // one operation in flight: no new request right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while previous one still pending");

    // a stalled result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !(rsp.valid && !rsp.ready))
        else $error("output register loaded while result stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_FULL_DROP) |-> (rsp.now_full && !rsp.now_empty))
        else $error("dropped push reported with deque not full");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_EMPTY_POP)
            |-> (rsp.now_empty && rsp.value_out == VALUE_EMPTY))
        else $error("empty pop result inconsistent");
`endif

endmodule

[tb/tb.sv]
// tb: self-checking testbench of circular_deque, driving random and directed
// deque operations and checking each result word against a shadow deque
// depends on cdq_pkg, cdq_if and the circular_deque rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 29;

    typedef struct {
        logic signed [WORD_W-1:0] value;
        logic [1:0]               status;
        logic                     empty;
        logic                     full;
    } deque_answer_t;

    logic clk;
    logic rst_n;

    cdq_req_if req ();
    cdq_rsp_if rsp ();

    circular_deque uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // shadow deque: front slot is shadow_head, count entries wrap modulo DEPTH
    logic signed [WORD_W-1:0] shadow_ring [DEPTH];
    int                       shadow_head;
    int                       shadow_count;

    deque_answer_t answer_q [$];
    deque_answer_t oldest;
    int            mismatches;
    int            cycles;
    bit            send_gaps;
    bit            recv_stalls;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic deque_answer_t deque_apply(input logic [1:0] op,
                                                  input logic signed [WORD_W-1:0] data);
        deque_answer_t ans;
        int            slot;
        ans.value  = VALUE_PUSH;
        ans.status = ST_DONE;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (shadow_count == DEPTH)
                begin
                    ans.status = ST_FULL_DROP;
                end
                else
                begin
                    if (shadow_count == 0)
                        shadow_head = 0;
                    else if (op == OP_PUSH_FRONT)
                        shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    slot = (op == OP_PUSH_FRONT) ? shadow_head
                                                 : (shadow_head + shadow_count) % DEPTH;
                    shadow_ring[slot] = data;
                    shadow_count++;
                end
            end
            default:
            begin
                if (shadow_count == 0)
                begin
                    ans.status = ST_EMPTY_POP;
                    ans.value  = VALUE_EMPTY;
                end
                else
                begin
                    if (op == OP_POP_FRONT)
                    begin
                        ans.value   = shadow_ring[shadow_head];
                        shadow_head = (shadow_head + 1) % DEPTH;
                    end
                    else
                    begin
                        ans.value = shadow_ring[(shadow_head + shadow_count - 1) % DEPTH];
                    end
                    shadow_count--;
                    // last entry gone: ring restarts at slot 0
                    if (shadow_count == 0)
                        shadow_head = 0;
                end
            end
        endcase
        ans.empty = (shadow_count == 0);
        ans.full  = (shadow_count == DEPTH);
        return ans;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    // result word is checked before the request word of the same edge is predicted
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (answer_q.size() == 0)
            begin
                report_mismatch($sformatf("result word with nothing pending, value %0d",
                                          rsp.value_out));
            end
            else
            begin
                oldest = answer_q[0];
                answer_q.delete(0);
                if (rsp.value_out !== oldest.value)
                    report_mismatch($sformatf("value_out %0d, want %0d",
                                              rsp.value_out, oldest.value));
                if (rsp.status !== oldest.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              rsp.status, oldest.status));
                if (rsp.now_empty !== oldest.empty)
                    report_mismatch($sformatf("now_empty %b, want %b",
                                              rsp.now_empty, oldest.empty));
                if (rsp.now_full !== oldest.full)
                    report_mismatch($sformatf("now_full %b, want %b",
                                              rsp.now_full, oldest.full));
            end
        end
        if (rst_n && req.valid && req.ready)
            answer_q = {answer_q, deque_apply(req.op, req.data_in)};
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge clk)
        rsp.ready <= recv_stalls ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send_word(input logic [1:0] op, input logic signed [WORD_W-1:0] data);
        while (send_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid   <= 1'b1;
        req.op      <= op;
        req.data_in <= data;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_empty_pops();
        send_word(OP_POP_FRONT, pick_word());
        send_word(OP_POP_BACK, pick_word());
    endtask

    task automatic test_fill_to_overflow();
        send_word(OP_PUSH_BACK, 32'h7fff_ffff);
        send_word(OP_PUSH_FRONT, 32'h8000_0000);
        send_word(OP_PUSH_BACK, '0);
        send_word(OP_PUSH_FRONT, '1);
        send_word(OP_PUSH_BACK, 32'h5555_5555);
        send_word(OP_PUSH_FRONT, 32'haaaa_aaaa);
        send_word(OP_PUSH_BACK, 32'sd1);
        send_word(OP_PUSH_FRONT, pick_word());
        // deque is full now, both pushes must be dropped
        send_word(OP_PUSH_BACK, pick_word());
        send_word(OP_PUSH_FRONT, pick_word());
    endtask

    task automatic test_drain_both_ends();
        for (int i = 0; i < DEPTH; i++)
            send_word((i % 2) ? OP_POP_BACK : OP_POP_FRONT, pick_word());
        send_word(OP_POP_BACK, pick_word());
    endtask

    task automatic test_refill_after_drain();
        send_word(OP_PUSH_FRONT, pick_word());
        send_word(OP_POP_FRONT, pick_word());
        send_word(OP_PUSH_BACK, pick_word());
        send_word(OP_POP_BACK, pick_word());
    endtask

    // push share swings every 40 words so the deque walks between empty and full
    task automatic test_random_walk(input int count);
        int         push_pct;
        logic [1:0] op;
        push_pct = 50;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            if ($urandom_range(99) < push_pct)
                op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else
                op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
            send_word(op, pick_word());
        end
    endtask

    task automatic test_pause_until_drained(input int count);
        // withdraw the last word so it is not taken a second time while waiting
        req.valid <= 1'b0;
        while (answer_q.size() != 0)
            @(negedge clk);
        test_random_walk(count);
    endtask

    task automatic test_back_to_back(input int count);
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        test_random_walk(count);
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        req.valid    = 1'b0;
        req.op       = OP_PUSH_BACK;
        req.data_in  = '0;
        rsp.ready    = 1'b0;
        send_gaps    = 1'b1;
        recv_stalls  = 1'b1;
        mismatches   = 0;
        cycles       = 0;
        shadow_head  = 0;
        shadow_count = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_pops();
        test_fill_to_overflow();
        test_drain_both_ends();
        test_refill_after_drain();
        test_random_walk(900);
        test_pause_until_drained(100);
        test_back_to_back(300);
        test_random_walk(125);
        req.valid <= 1'b0;

        while (answer_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/core/cdq_pkg.sv
rtl/core/cdq_if.sv
rtl/core/cdq_ctl.sv
rtl/core/cdq_dp.sv
rtl/core/circular_deque.sv
tb/tb.sv
